/* design/mfmr_pkg.sv */
// Package for the multi-format max reducer: element type codes and the
// per-type compare function. No dependencies.
package mfmr_pkg;

  typedef enum logic [3:0] {
    TYPE_U8   = 4'd0,
    TYPE_U16  = 4'd1,
    TYPE_U32  = 4'd2,
    TYPE_S8   = 4'd3,
    TYPE_S16  = 4'd4,
    TYPE_S32  = 4'd5,
    TYPE_E4M3 = 4'd6,
    TYPE_E5M2 = 4'd7,
    TYPE_F16  = 4'd8,
    TYPE_F32  = 4'd9
  } elem_type_t;

  localparam logic [31:0] MASK_8  = 32'h0000_00FF;
  localparam logic [31:0] MASK_16 = 32'h0000_FFFF;

  // Width mask of the type; codes without meaning act as u32
  function automatic logic [31:0] type_mask(input logic [3:0] t);
    logic [31:0] m;
    unique case (t)
      TYPE_U8, TYPE_S8, TYPE_E4M3, TYPE_E5M2: m = MASK_8;
      TYPE_U16, TYPE_S16, TYPE_F16:           m = MASK_16;
      default:                                m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic type_is_float(input logic [3:0] t);
    return (t == TYPE_E4M3) || (t == TYPE_E5M2) || (t == TYPE_F16) || (t == TYPE_F32);
  endfunction

  // IEEE-like a < b; ma/mb are magnitude fields, inf its all-ones exponent code
  function automatic logic float_less(input logic [30:0] ma, input logic [30:0] mb,
                                      input logic sa, input logic sb,
                                      input logic [30:0] inf);
    logic r;
    if (ma > inf || mb > inf) r = 1'b0;
    else if (ma == '0 && mb == '0) r = 1'b0;
    else if (sa != sb) r = sa;
    else if (!sa) r = ma < mb;
    else r = ma > mb;
    return r;
  endfunction

  // running a < candidate b under type t
  function automatic logic type_less(input logic [3:0] t, input logic [31:0] a,
                                     input logic [31:0] b);
    logic [31:0] am, bm;
    logic r;
    am = a & type_mask(t);
    bm = b & type_mask(t);
    unique case (t)
      TYPE_S8:   r = {~am[7],  am[6:0]}  < {~bm[7],  bm[6:0]};
      TYPE_S16:  r = {~am[15], am[14:0]} < {~bm[15], bm[14:0]};
      TYPE_S32:  r = {~am[31], am[30:0]} < {~bm[31], bm[30:0]};
      TYPE_E4M3: r = float_less({24'd0, a[6:0]}, {24'd0, b[6:0]}, a[7], b[7], 31'h78);
      TYPE_E5M2: r = float_less({24'd0, a[6:0]}, {24'd0, b[6:0]}, a[7], b[7], 31'h7C);
      TYPE_F16:  r = float_less({16'd0, a[14:0]}, {16'd0, b[14:0]}, a[15], b[15],
                                31'h7C00);
      TYPE_F32:  r = float_less(a[30:0], b[30:0], a[31], b[31], 31'h7F80_0000);
      default:   r = am < bm;
    endcase
    return r;
  endfunction

endpackage

/* design/multi_format_max_reduce.sv */
// Multi-format max reducer: one transfer a cycle in, one result per group out.
// The element type is set through the cfg channel; typing lives in mfmr_pkg.
//
// Usage:
//  - s_axis: tdata = element_value, tuser = keep, tlast = last_element.
//  - m_axis: tdata = max_value, tuser = group_empty; one transfer per group.
//  - cfg: writes element_type (low 4 bits); always ready, write only while idle.
// Latency: a group's result appears on m_axis the cycle after its last input
// transfer. Throughput: one input transfer every cycle unless a tlast
// stalls on an untaken result; the single compare-and-select between the
// input port and the running-max register sets that figure.
// The output register holds one result; input keeps flowing while it waits
// as long as no second group ends. A tlast arriving while the result is still
// untaken stalls s_axis_tready until m_axis drains.
// Reset clears the element type to u8, the running maximum and m_axis_tvalid.
module multi_format_max_reduce
  import mfmr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] element_value
  input  logic        s_axis_tuser,   // [0] keep
  input  logic        s_axis_tlast,   // last_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] max_value
  output logic        m_axis_tuser,   // [0] group_empty
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  logic [3:0]  element_type;
  logic [31:0] running_max, running_max_next, stored;
  logic        have_element, have_element_next;
  logic        take, out_free;

  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = out_free || !s_axis_tlast;
  assign take          = s_axis_tvalid && s_axis_tready;

  // compare-and-select
  always_comb begin
    stored = type_is_float(element_type) ? s_axis_tdata
                                         : (s_axis_tdata & type_mask(element_type));
    running_max_next  = running_max;
    have_element_next = have_element;
    if (s_axis_tuser) begin
      if (!have_element || type_less(element_type, running_max, s_axis_tdata))
        running_max_next = stored;
      have_element_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type  <= TYPE_U8;
      running_max   <= '0;
      have_element  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) element_type <= cfg_data;
      if (take && s_axis_tlast) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (take) begin
        if (s_axis_tlast) begin
          running_max   <= '0;
          have_element  <= 1'b0;
        end else begin
          running_max  <= running_max_next;
          have_element <= have_element_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take && s_axis_tlast) begin
      m_axis_tuser <= !have_element_next;
      m_axis_tdata <= !have_element_next ? 32'd0 :
                      type_is_float(element_type) ? running_max_next
                      : (running_max_next & type_mask(element_type));
    end
  end

endmodule

/* design/mfmr_checker.sv */
// Port-level checker for the multi-format max reducer, bound to the top.
// Depends on multi_format_max_reduce ports only.
module mfmr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a last transfer produces a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result after last transfer");

  // empty group reports zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("empty group with nonzero value");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  // a rising result valid must follow a last transfer
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without last transfer");

endmodule

bind multi_format_max_reduce mfmr_checker u_mfmr_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

/* bench/tb.sv */
// Testbench for multi_format_max_reduce: directed and random groups,
// checked against an in-bench max predictor. Depends on mfmr_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import mfmr_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        keep;
    logic        last;
  } elem_t;

  typedef struct packed {
    logic [31:0] max_value;
    logic        empty;
  } result_t;

  // directed row: optional typed-in result
  typedef struct packed {
    logic [31:0] value;
    logic        keep;
    logic        last;
    logic        fixed;
    logic [31:0] fixed_max;
    logic        fixed_empty;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  multi_format_max_reduce u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [3:0]  cur_type = 4'd0;
  logic [31:0] run_max = '0;
  logic        have_max = 1'b0;
  result_t     expected_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_rx = 1'b0;

  function automatic logic [31:0] width_mask(input logic [3:0] t);
    case (t)
      TYPE_U8, TYPE_S8, TYPE_E4M3, TYPE_E5M2: return 32'hFF;
      TYPE_U16, TYPE_S16, TYPE_F16:           return 32'hFFFF;
      default:                                return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic bit is_fp(input logic [3:0] t);
    return t == TYPE_E4M3 || t == TYPE_E5M2 || t == TYPE_F16 || t == TYPE_F32;
  endfunction

  // append one expected result at the tail of the queue
  function automatic void enqueue_result(input result_t r);
    expected_q = {expected_q, r};
  endfunction

  // a < b, IEEE-like on the low bits; NaN never compares true
  function automatic bit fp_lt(input logic [31:0] a, input logic [31:0] b,
                               input int ebits, input int mbits);
    int          nmag;
    logic [31:0] mmask, infc, ma, mb;
    bit          sa, sb;
    nmag = ebits + mbits;
    mmask = (32'd1 << nmag) - 1;
    infc = ((32'd1 << ebits) - 1) << mbits;
    ma = a & mmask;
    mb = b & mmask;
    sa = a[nmag];
    sb = b[nmag];
    if (ma > infc || mb > infc) return 0;
    if (ma == 0 && mb == 0) return 0;
    if (sa != sb) return sa;
    if (!sa) return ma < mb;
    return ma > mb;
  endfunction

  function automatic bit elem_lt(input logic [3:0] t, input logic [31:0] a,
                                 input logic [31:0] b);
    logic [31:0] wm, sbit;
    wm = width_mask(t);
    case (t)
      TYPE_E4M3: return fp_lt(a, b, 4, 3);
      TYPE_E5M2: return fp_lt(a, b, 5, 2);
      TYPE_F16:  return fp_lt(a, b, 5, 10);
      TYPE_F32:  return fp_lt(a, b, 8, 23);
      default: begin
        sbit = (t == TYPE_S8) ? 32'h80 : (t == TYPE_S16) ? 32'h8000 :
               (t == TYPE_S32) ? 32'h8000_0000 : 32'h0;
        return ((a & wm) ^ sbit) < ((b & wm) ^ sbit);
      end
    endcase
  endfunction

  // fold one accepted element into the running max; queue a result on last
  task automatic predict_max(input elem_t e);
    logic [31:0] wm, stored;
    result_t     r;
    wm = width_mask(cur_type);
    stored = is_fp(cur_type) ? e.value : (e.value & wm);
    if (e.keep) begin
      if (!have_max) begin
        run_max = stored;
        have_max = 1'b1;
      end else if (elem_lt(cur_type, run_max, e.value)) begin
        run_max = stored;
      end
    end
    if (e.last) begin
      r.max_value = have_max ? (is_fp(cur_type) ? run_max : (run_max & wm)) : 32'h0;
      r.empty = !have_max;
      enqueue_result(r);
      run_max = '0;
      have_max = 1'b0;
    end
  endtask

  // result checking
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result max_value=%h group_empty=%b", m_axis_tdata,
               m_axis_tuser);
        errors++;
      end else begin
        result_t x;
        x = expected_q.pop_front();
        if (m_axis_tdata !== x.max_value) begin
          $error("max_value expected %h actual %h", x.max_value, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== x.empty) begin
          $error("group_empty expected %b actual %b", x.empty, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // receiver: random stall bursts, long hold when asked
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rx) m_axis_tready <= 1'b0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || hold_rx)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_elem(input elem_t e);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 13);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= e.value;
    s_axis_tuser <= e.keep;
    s_axis_tlast <= e.last;
    do @(posedge clk); while (!s_axis_tready);
    predict_max(e);
  endtask

  task automatic drain_out();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_type(input logic [3:0] t);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_type = t;
  endtask

  // random element biased toward interesting encodings
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0, 8'($urandom)};
      3: return {16'($urandom), $urandom_range(0, 1) ? 16'h8000 : 16'h0000};
      4: return {1'($urandom_range(0, 1)), 31'h7F80_0000 | 31'($urandom_range(0, 3))};
      5: return 32'($urandom_range(0, 1) ? 32'h7C00 : 32'h78) | 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_groups(input int count, input int maxlen);
    elem_t e;
    int    len;
    while (count > 0) begin
      len = $urandom_range(1, maxlen);
      for (int i = 0; i < len; i++) begin
        e.value = pick_value();
        e.keep = $urandom_range(0, 4) != 0;
        e.last = (i == len - 1);
        send_elem(e);
        count--;
      end
    end
  endtask

  row_t dir_rows[] = '{
    // empty group right after reset (type u8)
    '{32'h0000_0055, 1'b0, 1'b1, 1'b1, 32'h0, 1'b1},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFF, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h1234_5680, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_00FF, 1'b0, 1'b1, 1'b1, 32'h80, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0, 1'b1}
  };

  // per-type directed groups (predicted)
  logic [31:0] type_vals[10][4] = '{
    '{32'h0, 32'hFF, 32'h7F, 32'h1FF},
    '{32'hFFFF, 32'h0, 32'h18000, 32'h7FFF},
    '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1},
    '{32'h80, 32'h7F, 32'hFF, 32'h100},
    '{32'h8000, 32'h7FFF, 32'hFFFF, 32'h0},
    '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0},
    '{32'h7F, 32'h80, 32'h00, 32'h78},
    '{32'h7D, 32'hFC, 32'h7C, 32'h80},
    '{32'h8000, 32'h0000, 32'h7C01, 32'h7C00},
    '{32'h7FC0_0000, 32'h8000_0000, 32'hFF80_0000, 32'h7F80_0000}
  };

  initial begin
    elem_t e;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      e.value = dir_rows[i].value;
      e.keep = dir_rows[i].keep;
      e.last = dir_rows[i].last;
      send_elem(e);
      // typed-in result takes the place of the predicted one
      if (dir_rows[i].fixed) begin
        void'(expected_q.pop_back());
        enqueue_result('{dir_rows[i].fixed_max, dir_rows[i].fixed_empty});
      end
    end
    drain_out();

    // every type, NaN first and later, signed zeros; also a meaningless code
    for (int t = 0; t < 10; t++) begin
      write_type(4'(t));
      for (int k = 0; k < 4; k++) send_elem('{type_vals[t][k], 1'b1, k == 3});
      drain_out();
    end
    write_type(4'd15);
    send_elem('{32'h8000_0000, 1'b1, 1'b0});
    send_elem('{32'h7FFF_FFFF, 1'b1, 1'b1});
    drain_out();

    // type change inside a group
    write_type(TYPE_S8);
    send_elem('{32'h0000_0080, 1'b1, 1'b0});
    cfg_valid <= 1'b1;
    cfg_data <= TYPE_U16;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_type = TYPE_U16;
    send_elem('{32'h0001_0070, 1'b1, 1'b1});
    drain_out();

    // random part across all types, extremes included
    for (int p = 0; p < 11; p++) begin
      write_type(p == 10 ? 4'($urandom_range(10, 15)) : 4'(p));
      if (p == 3) begin
        // long receiver hold while the sender keeps pushing short groups
        fork
          begin
            hold_rx = 1'b1;
            repeat (60) @(posedge clk);
            hold_rx = 1'b0;
          end
          random_groups(40, 2);
        join
      end
      random_groups(120, 12);
      drain_out();
    end
    calm = 1'b1;
    random_groups(60, 6);
    drain_out();

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("Simulation PASSED");
    else begin
      if (expected_q.size() != 0) $error("%0d results never arrived", expected_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
